[design/dtsd_pkg.sv]
`default_nettype none
package dtsd_pkg;

  localparam int MAX_DIGITS = 17;
  localparam int DIDX_W = $clog2(MAX_DIGITS);
  localparam int LEN_W = $clog2(MAX_DIGITS + 1);

  localparam logic [10:0] EXP_ALL_ONES = 11'h7FF;
  localparam logic [52:0] HIDDEN_BIT = 53'h0010000000000000;
  localparam logic signed [11:0] EXP_BIAS = 12'sd1075;
  localparam logic signed [11:0] EXP_DENORM = -12'sd1074;

  // k = ceil((-61 - pe) * log10(2)) + 347, done as a Q32 product of
  // u = 1987 - pe (always positive) with a folded offset.
  localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;
  localparam logic [63:0] KIDX_BIAS =
    64'd8796093022208 - 64'd2048 * 64'd1292913986 + 64'd4294967295;
  localparam logic signed [12:0] KIDX_UOFS = 13'sd1987;
  localparam logic signed [12:0] KIDX_SUB = 13'sd1701;
  localparam logic [6:0] LAST_POW_IDX = 7'd86;
  localparam logic signed [9:0] K_BASE = 10'sd348;

  localparam logic [34:0] ROUND_HALF = 35'h0_8000_0000;
  localparam logic [6:0] FRAC_STEP_MAX = 7'd64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM,
    ST_BOUND,
    ST_KMUL,
    ST_KIDX,
    ST_HMUL,
    ST_SETUP,
    ST_SPLIT,
    ST_KAPPA,
    ST_IDIV,
    ST_IDIG,
    ST_FRAC,
    ST_WMUL,
    ST_RND_A,
    ST_RND_B,
    ST_EMIT
  } dtsd_state_t;

  typedef enum logic [1:0] {
    SEL_W = 2'd0,
    SEL_P = 2'd1,
    SEL_M = 2'd2
  } dtsd_msel_t;

  function automatic logic [63:0] tens(input logic [4:0] i);
    logic [63:0] r;
    r = 64'd1;
    case (i)
      5'd0: r = 64'd1;
      5'd1: r = 64'd10;
      5'd2: r = 64'd100;
      5'd3: r = 64'd1000;
      5'd4: r = 64'd10000;
      5'd5: r = 64'd100000;
      5'd6: r = 64'd1000000;
      5'd7: r = 64'd10000000;
      5'd8: r = 64'd100000000;
      5'd9: r = 64'd1000000000;
      5'd10: r = 64'd10000000000;
      5'd11: r = 64'd100000000000;
      5'd12: r = 64'd1000000000000;
      5'd13: r = 64'd10000000000000;
      5'd14: r = 64'd100000000000000;
      5'd15: r = 64'd1000000000000000;
      5'd16: r = 64'd10000000000000000;
      5'd17: r = 64'd100000000000000000;
      5'd18: r = 64'd1000000000000000000;
      5'd19: r = 64'd10000000000000000000;
      default: r = 64'd0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] pow_sig(input logic [6:0] i);
    logic [63:0] r;
    r = 64'h0;
    case (i)
      7'd0: r = 64'hfa8fd5a0081c0288; 7'd1: r = 64'hbaaee17fa23ebf76;
      7'd2: r = 64'h8b16fb203055ac76; 7'd3: r = 64'hcf42894a5dce35ea;
      7'd4: r = 64'h9a6bb0aa55653b2d; 7'd5: r = 64'he61acf033d1a45df;
      7'd6: r = 64'hab70fe17c79ac6ca; 7'd7: r = 64'hff77b1fcbebcdc4f;
      7'd8: r = 64'hbe5691ef416bd60c; 7'd9: r = 64'h8dd01fad907ffc3c;
      7'd10: r = 64'hd3515c2831559a83; 7'd11: r = 64'h9d71ac8fada6c9b5;
      7'd12: r = 64'hea9c227723ee8bcb; 7'd13: r = 64'haecc49914078536d;
      7'd14: r = 64'h823c12795db6ce57; 7'd15: r = 64'hc21094364dfb5637;
      7'd16: r = 64'h9096ea6f3848984f; 7'd17: r = 64'hd77485cb25823ac7;
      7'd18: r = 64'ha086cfcd97bf97f4; 7'd19: r = 64'hef340a98172aace5;
      7'd20: r = 64'hb23867fb2a35b28e; 7'd21: r = 64'h84c8d4dfd2c63f3b;
      7'd22: r = 64'hc5dd44271ad3cdba; 7'd23: r = 64'h936b9fcebb25c996;
      7'd24: r = 64'hdbac6c247d62a584; 7'd25: r = 64'ha3ab66580d5fdaf6;
      7'd26: r = 64'hf3e2f893dec3f126; 7'd27: r = 64'hb5b5ada8aaff80b8;
      7'd28: r = 64'h87625f056c7c4a8b; 7'd29: r = 64'hc9bcff6034c13053;
      7'd30: r = 64'h964e858c91ba2655; 7'd31: r = 64'hdff9772470297ebd;
      7'd32: r = 64'ha6dfbd9fb8e5b88f; 7'd33: r = 64'hf8a95fcf88747d94;
      7'd34: r = 64'hb94470938fa89bcf; 7'd35: r = 64'h8a08f0f8bf0f156b;
      7'd36: r = 64'hcdb02555653131b6; 7'd37: r = 64'h993fe2c6d07b7fac;
      7'd38: r = 64'he45c10c42a2b3b06; 7'd39: r = 64'haa242499697392d3;
      7'd40: r = 64'hfd87b5f28300ca0e; 7'd41: r = 64'hbce5086492111aeb;
      7'd42: r = 64'h8cbccc096f5088cc; 7'd43: r = 64'hd1b71758e219652c;
      7'd44: r = 64'h9c40000000000000; 7'd45: r = 64'he8d4a51000000000;
      7'd46: r = 64'had78ebc5ac620000; 7'd47: r = 64'h813f3978f8940984;
      7'd48: r = 64'hc097ce7bc90715b3; 7'd49: r = 64'h8f7e32ce7bea5c70;
      7'd50: r = 64'hd5d238a4abe98068; 7'd51: r = 64'h9f4f2726179a2245;
      7'd52: r = 64'hed63a231d4c4fb27; 7'd53: r = 64'hb0de65388cc8ada8;
      7'd54: r = 64'h83c7088e1aab65db; 7'd55: r = 64'hc45d1df942711d9a;
      7'd56: r = 64'h924d692ca61be758; 7'd57: r = 64'hda01ee641a708dea;
      7'd58: r = 64'ha26da3999aef774a; 7'd59: r = 64'hf209787bb47d6b85;
      7'd60: r = 64'hb454e4a179dd1877; 7'd61: r = 64'h865b86925b9bc5c2;
      7'd62: r = 64'hc83553c5c8965d3d; 7'd63: r = 64'h952ab45cfa97a0b3;
      7'd64: r = 64'hde469fbd99a05fe3; 7'd65: r = 64'ha59bc234db398c25;
      7'd66: r = 64'hf6c69a72a3989f5c; 7'd67: r = 64'hb7dcbf5354e9bece;
      7'd68: r = 64'h88fcf317f22241e2; 7'd69: r = 64'hcc20ce9bd35c78a5;
      7'd70: r = 64'h98165af37b2153df; 7'd71: r = 64'he2a0b5dc971f303a;
      7'd72: r = 64'ha8d9d1535ce3b396; 7'd73: r = 64'hfb9b7cd9a4a7443c;
      7'd74: r = 64'hbb764c4ca7a44410; 7'd75: r = 64'h8bab8eefb6409c1a;
      7'd76: r = 64'hd01fef10a657842c; 7'd77: r = 64'h9b10a4e5e9913129;
      7'd78: r = 64'he7109bfba19c0c9d; 7'd79: r = 64'hac2820d9623bf429;
      7'd80: r = 64'h80444b5e7aa7cf85; 7'd81: r = 64'hbf21e44003acdd2d;
      7'd82: r = 64'h8e679c2f5e44ff8f; 7'd83: r = 64'hd433179d9c8cb841;
      7'd84: r = 64'h9e19db92b4e31ba9; 7'd85: r = 64'heb96bf6ebadf77d9;
      7'd86: r = 64'haf87023b9bf0ee6b;
      default: r = 64'h0;
    endcase
    return r;
  endfunction

  function automatic logic signed [11:0] pow_exp(input logic [6:0] i);
    logic signed [11:0] r;
    r = 12'sd0;
    case (i)
      7'd0: r = -12'sd1220; 7'd1: r = -12'sd1193; 7'd2: r = -12'sd1166;
      7'd3: r = -12'sd1140; 7'd4: r = -12'sd1113; 7'd5: r = -12'sd1087;
      7'd6: r = -12'sd1060; 7'd7: r = -12'sd1034; 7'd8: r = -12'sd1007;
      7'd9: r = -12'sd980;  7'd10: r = -12'sd954; 7'd11: r = -12'sd927;
      7'd12: r = -12'sd901; 7'd13: r = -12'sd874; 7'd14: r = -12'sd847;
      7'd15: r = -12'sd821; 7'd16: r = -12'sd794; 7'd17: r = -12'sd768;
      7'd18: r = -12'sd741; 7'd19: r = -12'sd715; 7'd20: r = -12'sd688;
      7'd21: r = -12'sd661; 7'd22: r = -12'sd635; 7'd23: r = -12'sd608;
      7'd24: r = -12'sd582; 7'd25: r = -12'sd555; 7'd26: r = -12'sd529;
      7'd27: r = -12'sd502; 7'd28: r = -12'sd475; 7'd29: r = -12'sd449;
      7'd30: r = -12'sd422; 7'd31: r = -12'sd396; 7'd32: r = -12'sd369;
      7'd33: r = -12'sd343; 7'd34: r = -12'sd316; 7'd35: r = -12'sd289;
      7'd36: r = -12'sd263; 7'd37: r = -12'sd236; 7'd38: r = -12'sd210;
      7'd39: r = -12'sd183; 7'd40: r = -12'sd157; 7'd41: r = -12'sd130;
      7'd42: r = -12'sd103; 7'd43: r = -12'sd77;  7'd44: r = -12'sd50;
      7'd45: r = -12'sd24;  7'd46: r = 12'sd3;    7'd47: r = 12'sd30;
      7'd48: r = 12'sd56;   7'd49: r = 12'sd83;   7'd50: r = 12'sd109;
      7'd51: r = 12'sd136;  7'd52: r = 12'sd162;  7'd53: r = 12'sd189;
      7'd54: r = 12'sd216;  7'd55: r = 12'sd242;  7'd56: r = 12'sd269;
      7'd57: r = 12'sd295;  7'd58: r = 12'sd322;  7'd59: r = 12'sd348;
      7'd60: r = 12'sd375;  7'd61: r = 12'sd402;  7'd62: r = 12'sd428;
      7'd63: r = 12'sd455;  7'd64: r = 12'sd481;  7'd65: r = 12'sd508;
      7'd66: r = 12'sd534;  7'd67: r = 12'sd561;  7'd68: r = 12'sd588;
      7'd69: r = 12'sd614;  7'd70: r = 12'sd641;  7'd71: r = 12'sd667;
      7'd72: r = 12'sd694;  7'd73: r = 12'sd720;  7'd74: r = 12'sd747;
      7'd75: r = 12'sd774;  7'd76: r = 12'sd800;  7'd77: r = 12'sd827;
      7'd78: r = 12'sd853;  7'd79: r = 12'sd880;  7'd80: r = 12'sd907;
      7'd81: r = 12'sd933;  7'd82: r = 12'sd960;  7'd83: r = 12'sd986;
      7'd84: r = 12'sd1013; 7'd85: r = 12'sd1039; 7'd86: r = 12'sd1066;
      default: r = 12'sd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[design/double_to_shortest_decimal_digits.sv]
// Converts the bit pattern of an IEEE double into its short decimal digit
// string by the Grisu2 scheme. A request on the s_ channel carries the 64-bit
// pattern; the sign bit is ignored. The m_ channel returns one request per
// digit, most significant first, each carrying the digit, the digit count and
// the decimal exponent K (value = digits * 10^K); m_tlast marks the final
// digit. Zero gives the single digit 0 with exponent 1. An all-ones exponent
// (infinity or NaN) gives one request with m_tuser set and digit 0.
// The block works on one conversion at a time: s_tready is high only while it
// is idle. A conversion runs a six-step leading zero search and three rounded
// 64x64 high products, each built from four passes through the single 32x32
// multiplier, then a four-step restoring digit divide per integer digit, the
// fractional digit steps with a scaling of the rounding window after them,
// and the rounding steps, and then delivers the digits. Zero, infinity and
// NaN go straight from idle to delivery.
// When the receiver stalls, the current digit is held on m_tdata until taken.
// Reset returns the block to idle with no output pending; no clearing pass.
`default_nettype none
module double_to_shortest_decimal_digits
  import dtsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // [63:0] value_bits
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [23:0] m_tdata,   // [3:0] digit, [8:4] digit_count,
                                      // [18:9] dec_exponent, [23:19] zero
  output logic             m_tlast,   // is_last
  output logic             m_tuser    // not_finite
);

  dtsd_state_t st, st_next;

  // Shared multiplier port.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  dtsd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // Working registers.
  logic [52:0]        f_r;
  logic signed [11:0] e_r;
  logic [63:0]        nrm;       // normalized significand w after the search
  logic [5:0]         nz;
  logic [2:0]         nstep;
  logic [63:0]        pf, mf;
  logic signed [11:0] pe;
  logic [6:0]         pidx;
  logic signed [9:0]  kexp;
  logic [1:0]         msel;
  logic [2:0]         ph;
  logic [34:0]        mid;
  logic [63:0]        hi;
  logic [63:0]        wv, wp, wm;
  logic [5:0]         sh;
  logic [63:0]        delta, wpw;
  logic [31:0]        p1;
  logic [63:0]        p2;
  logic signed [7:0]  kappa;
  logic [3:0]         q;
  logic [1:0]         dstep;
  logic [LEN_W-1:0]   len;
  logic [3:0]         last_dig;
  logic [3:0]         digit_store [MAX_DIGITS];
  logic [6:0]         steps;
  logic [63:0]        rest, stp, wlim, wscale;
  logic [63:0]        rsum, rdr, rwr;
  logic [LEN_W-1:0]   oidx;
  logic               nf_r;

  // Decode of the incoming pattern.
  logic [10:0] in_bexp;
  logic [51:0] in_mant;
  assign in_bexp = s_tdata[62:52];
  assign in_mant = s_tdata[51:0];

  // Leading-zero search step: halve the window each cycle.
  logic [5:0]  nwin;
  logic        ntop_zero;
  assign nwin = 6'd32 >> nstep;
  assign ntop_zero = (nrm & ~({64{1'b1}} >> nwin)) == 64'd0;

  // Table index from the Q32 product.
  logic signed [12:0] kq_u;
  logic [63:0]        kq_t;
  logic signed [12:0] kraw;
  logic [9:0]         kdiv;
  logic [6:0]         pidx_new;
  assign kq_u = KIDX_UOFS - {pe[11], pe};
  assign kq_t = mul_p + KIDX_BIAS;
  assign kraw = {1'b0, kq_t[43:32]} - KIDX_SUB;
  assign kdiv = {1'b0, kraw[11:3]} + 10'd1;
  always_comb begin
    if (kraw[12]) begin
      pidx_new = 7'd0;
    end else if (kdiv > {3'b0, LAST_POW_IDX}) begin
      pidx_new = LAST_POW_IDX;
    end else begin
      pidx_new = kdiv[6:0];
    end
  end

  // Operand of the high product.
  logic [63:0] hx, hy;
  assign hy = pow_sig(pidx);
  always_comb begin
    case (dtsd_msel_t'(msel))
      SEL_W:   hx = nrm;
      SEL_P:   hx = pf;
      SEL_M:   hx = mf;
      default: hx = nrm;
    endcase
  end
  logic [63:0] hadj, hres;
  always_comb begin
    case (dtsd_msel_t'(msel))
      SEL_P:   hadj = {64{1'b1}};
      SEL_M:   hadj = 64'd1;
      default: hadj = 64'd0;
    endcase
  end
  assign hres = hi + mul_p + {61'b0, mid[34:32]};

  // Shift amount of the fixed-point split.
  logic signed [11:0] pexp;
  logic signed [12:0] ssum, sneg;
  assign pexp = pow_exp(pidx);
  assign ssum = {pe[11], pe} + {pexp[11], pexp} + 13'sd64;
  assign sneg = -ssum;

  logic [63:0] fmask;
  assign fmask = (64'd1 << sh) - 64'd1;

  // Number of integer digits of p1.
  logic signed [7:0] kappa_init;
  always_comb begin
    kappa_init = 8'sd1;
    for (int i = 1; i < 10; i++) begin
      if ({32'b0, p1} >= tens(5'(i))) kappa_init = kappa_init + 8'sd1;
    end
  end

  // Restoring digit divide, one quotient bit per cycle.
  logic signed [7:0] kappa_m1;
  logic [31:0]       dv;
  logic [34:0]       dtrial;
  logic              dfit;
  assign kappa_m1 = kappa - 8'sd1;
  assign dv = 32'(tens(kappa_m1[4:0]));
  assign dtrial = {3'b0, dv} << (2'd3 - dstep);
  assign dfit = {3'b0, p1} >= dtrial;

  logic [63:0] itmp;
  assign itmp = ({32'b0, p1} << sh) + p2;

  // Fractional digit step.
  logic [63:0] p2x, dx, p2m, fdig_full;
  logic [6:0]  steps_n;
  logic [7:0]  nk;
  assign p2x = (p2 << 3) + (p2 << 1);
  assign dx = (delta << 3) + (delta << 1);
  assign p2m = p2x & fmask;
  assign fdig_full = p2x >> sh;
  assign steps_n = steps + 7'd1;
  assign nk = 8'(-kappa_m1);

  // Digit write into the store.
  logic [3:0]       wdig;
  logic             wen;
  logic [LEN_W-1:0] len_n;
  always_comb begin
    wdig = (st == ST_FRAC) ? fdig_full[3:0] : q;
    wen = ((st == ST_FRAC) || (st == ST_IDIG)) && ((wdig != 4'd0) || (len != '0))
          && (len < LEN_W'(MAX_DIGITS));
    len_n = wen ? len + LEN_W'(1) : len;
  end

  logic frac_exit;
  assign frac_exit = (p2m < dx) || (len_n >= LEN_W'(MAX_DIGITS)) ||
                     (steps_n >= FRAC_STEP_MAX);

  // Rounding step condition.
  logic rnd_go;
  assign rnd_go = (rest < wlim) && (rdr >= stp) &&
                  ((rsum < wlim) || (rwr > rsum - wlim)) && (last_dig != 4'd0);

  logic emit_last;
  assign emit_last = (len == '0) || (oidx == len - LEN_W'(1));

  // Next state.
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: begin
        if (s_tvalid) begin
          if (in_bexp == EXP_ALL_ONES || (in_bexp == 11'd0 && in_mant == 52'd0)) begin
            st_next = ST_EMIT;
          end else begin
            st_next = ST_NORM;
          end
        end
      end
      ST_NORM:  if (nstep == 3'd5) st_next = ST_BOUND;
      ST_BOUND: st_next = ST_KMUL;
      ST_KMUL:  st_next = ST_KIDX;
      ST_KIDX:  st_next = ST_HMUL;
      ST_HMUL:  if (ph == 3'd4 && msel == SEL_M) st_next = ST_SETUP;
      ST_SETUP: st_next = ST_SPLIT;
      ST_SPLIT: st_next = ST_KAPPA;
      ST_KAPPA: st_next = ST_IDIV;
      ST_IDIV:  if (dstep == 2'd3) st_next = ST_IDIG;
      ST_IDIG: begin
        if (itmp <= delta) begin
          st_next = ST_RND_A;
        end else if (kappa_m1 == 8'sd0) begin
          st_next = ST_FRAC;
        end else begin
          st_next = ST_IDIV;
        end
      end
      ST_FRAC:  if (frac_exit) st_next = ST_WMUL;
      ST_WMUL:  if (ph == 3'd3) st_next = ST_RND_A;
      ST_RND_A: st_next = (len == '0) ? ST_EMIT : ST_RND_B;
      ST_RND_B: st_next = rnd_go ? ST_RND_A : ST_EMIT;
      ST_EMIT:  if (m_tready && emit_last) st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  // Handshake and multiplier operand outputs.
  always_comb begin
    s_tready = (st == ST_IDLE);
    m_tvalid = (st == ST_EMIT);
    mul_a = 32'd0;
    mul_b = 32'd0;
    case (st)
      ST_KMUL: begin
        mul_a = {20'b0, kq_u[11:0]};
        mul_b = LOG10_2_Q32;
      end
      ST_HMUL: begin
        mul_a = ph[0] ? hx[63:32] : hx[31:0];
        mul_b = ph[1] ? hy[63:32] : hy[31:0];
      end
      ST_WMUL: begin
        mul_a = ph[0] ? wpw[63:32] : wpw[31:0];
        mul_b = ph[1] ? wscale[63:32] : wscale[31:0];
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      digit_store[len[DIDX_W-1:0]] <= wdig;
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      oidx <= '0;
      nf_r <= 1'b0;
    end else begin
      if (wen) last_dig <= wdig;
      case (st)
        ST_IDLE: begin
          oidx <= '0;
          len <= '0;
          nz <= 6'd0;
          nstep <= 3'd0;
          nf_r <= (in_bexp == EXP_ALL_ONES);
          if (in_bexp == EXP_ALL_ONES) begin
            kexp <= 10'sd0;
          end else begin
            kexp <= 10'sd1;
          end
          if (in_bexp != 11'd0) begin
            f_r <= {1'b1, in_mant};
            nrm <= {11'b0, 1'b1, in_mant};
            e_r <= $signed({1'b0, in_bexp}) - EXP_BIAS;
          end else begin
            f_r <= {1'b0, in_mant};
            nrm <= {12'b0, in_mant};
            e_r <= EXP_DENORM;
          end
        end
        ST_NORM: begin
          nstep <= nstep + 3'd1;
          if (ntop_zero) begin
            nrm <= nrm << nwin;
            nz <= nz + nwin;
          end
        end
        ST_BOUND: begin
          pe <= e_r - $signed({6'b0, nz});
          pf <= nrm | (64'd1 << (nz - 6'd1));
          if (f_r == HIDDEN_BIT) begin
            mf <= (({11'b0, f_r} << 2) - 64'd1) << (nz - 6'd2);
          end else begin
            mf <= (({11'b0, f_r} << 1) - 64'd1) << (nz - 6'd1);
          end
        end
        ST_KIDX: begin
          pidx <= pidx_new;
          kexp <= K_BASE - $signed({pidx_new, 3'b0});
          msel <= SEL_W;
          ph <= 3'd0;
        end
        ST_HMUL: begin
          ph <= (ph == 3'd4) ? 3'd0 : ph + 3'd1;
          case (ph)
            3'd1: mid <= {3'b0, mul_p[63:32]} + ROUND_HALF;
            3'd2: begin
              mid <= mid + {3'b0, mul_p[31:0]};
              hi <= {32'b0, mul_p[63:32]};
            end
            3'd3: begin
              mid <= mid + {3'b0, mul_p[31:0]};
              hi <= hi + {32'b0, mul_p[63:32]} + hadj;
            end
            3'd4: begin
              msel <= msel + 2'd1;
              case (dtsd_msel_t'(msel))
                SEL_W:   wv <= hres;
                SEL_P:   wp <= hres;
                default: wm <= hres;
              endcase
            end
            default: ;
          endcase
        end
        ST_SETUP: begin
          sh <= sneg[5:0];
          delta <= wp - wm;
          wpw <= wp - wv;
        end
        ST_SPLIT: begin
          p1 <= 32'(wp >> sh);
          p2 <= wp & fmask;
          len <= '0;
          steps <= 7'd0;
        end
        ST_KAPPA: begin
          kappa <= kappa_init;
          dstep <= 2'd0;
          q <= 4'd0;
        end
        ST_IDIV: begin
          dstep <= dstep + 2'd1;
          if (dfit) begin
            p1 <= p1 - dtrial[31:0];
            q[2'd3 - dstep] <= 1'b1;
          end
        end
        ST_IDIG: begin
          len <= len_n;
          kappa <= kappa_m1;
          dstep <= 2'd0;
          q <= 4'd0;
          if (itmp <= delta) begin
            kexp <= kexp + 10'(kappa_m1);
            rest <= itmp;
            stp <= tens(kappa_m1[4:0]) << sh;
            wlim <= wpw;
          end
        end
        ST_FRAC: begin
          len <= len_n;
          p2 <= p2m;
          delta <= dx;
          kappa <= kappa_m1;
          steps <= steps_n;
          ph <= 3'd0;
          if (frac_exit) begin
            kexp <= kexp + 10'(kappa_m1);
            rest <= p2m;
            stp <= 64'd1 << sh;
            wscale <= (nk < 8'd20) ? tens(nk[4:0]) : 64'd0;
          end
        end
        ST_WMUL: begin
          ph <= ph + 3'd1;
          case (ph)
            3'd1: wlim <= mul_p;
            3'd2: wlim[63:32] <= wlim[63:32] + mul_p[31:0];
            3'd3: wlim[63:32] <= wlim[63:32] + mul_p[31:0];
            default: ;
          endcase
        end
        ST_RND_A: begin
          rsum <= rest + stp;
          rdr <= delta - rest;
          rwr <= wlim - rest;
        end
        ST_RND_B: begin
          if (rnd_go) begin
            last_dig <= last_dig - 4'd1;
            rest <= rsum;
          end
        end
        ST_EMIT: begin
          if (m_tready) oidx <= oidx + LEN_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Result request.
  logic [3:0] out_digit;
  logic [4:0] out_count;
  always_comb begin
    if (len == '0) begin
      out_digit = 4'd0;
      out_count = 5'd1;
    end else begin
      out_digit = (oidx == len - LEN_W'(1)) ? last_dig : digit_store[oidx[DIDX_W-1:0]];
      out_count = 5'(len);
    end
  end
  assign m_tdata = {5'b0, kexp, out_count, out_digit};
  assign m_tlast = emit_last;
  assign m_tuser = nf_r;

  // Checks.
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid) else $error("input ready while results pending");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready) else $error("accepted while busy");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready) else $error("no return to idle");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[3:0] <= 4'd9)) else $error("digit out of range");

endmodule
`default_nettype wire

[design/dtsd_mul.sv]
`default_nettype none
module dtsd_mul
  import dtsd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic      [63:0] p
);

  // Shared 32x32 multiplier; the product is registered.
  always_ff @(posedge clk) begin
    p <= {32'b0, a} * {32'b0, b};
  end

endmodule
`default_nettype wire
